[hdl/qrrs_pkg.sv]
// Shared types, constants and GF(256) helper functions for the QR Reed-Solomon encoder.
package qrrs_pkg;

  localparam int DataW     = 8;
  localparam int LenW      = 5;
  localparam int Slots     = 32;
  localparam int ResetLen  = 7;
  localparam int ResultCap = 30;

  typedef logic [DataW-1:0] gf_t;
  typedef logic [LenW-1:0]  len_t;
  typedef logic [Slots-1:0][DataW-1:0] coef_col_t;
  typedef logic [Slots-1:0][Slots-1:0][DataW-1:0] gen_tab_t;

  typedef struct packed {
    logic cfg_we;
    len_t cfg_len;
    logic cfg_ok;
    logic step;
    logic clear;
    logic load_drain;
    logic zero_drain;
    logic drain_shift;
    gf_t  fb;
  } cell_ctrl_t;

  function automatic gf_t gf_mul(gf_t a, gf_t b, logic [8:0] poly);
    gf_t acc;
    gf_t x;
    acc = '0;
    x   = a;
    for (int k = 0; k < DataW; k++) begin
      if (b[k]) begin
        acc = acc ^ x;
      end
      x = {x[DataW-2:0], 1'b0} ^ (x[DataW-1] ? poly[DataW-1:0] : gf_t'(0));
    end
    return acc;
  endfunction

  function automatic logic length_ok(len_t n, int max_parity);
    logic ok;
    case (n)
      len_t'(7), len_t'(10), len_t'(13), len_t'(15), len_t'(16), len_t'(17),
      len_t'(18), len_t'(20), len_t'(22), len_t'(24), len_t'(26), len_t'(28),
      len_t'(30): ok = 1'b1;
      default: ok = 1'b0;
    endcase
    return ok && (int'(n) <= max_parity);
  endfunction

  function automatic gen_tab_t gen_table(logic [8:0] poly, int max_parity);
    gen_tab_t tab;
    gf_t      c [Slots];
    gf_t      root;
    tab = '0;
    for (int n = 0; n < Slots; n++) begin
      for (int k = 0; k < Slots; k++) begin
        c[k] = '0;
      end
      c[0] = gf_t'(1);
      root = gf_t'(1);
      if (length_ok(len_t'(n), max_parity)) begin
        for (int i = 0; i < n; i++) begin
          for (int k = i + 1; k >= 1; k--) begin
            c[k] = c[k-1] ^ gf_mul(c[k], root, poly);
          end
          c[0] = gf_mul(c[0], root, poly);
          root = gf_mul(root, gf_t'(2), poly);
        end
      end
      for (int k = 0; k < Slots; k++) begin
        tab[n][k] = c[k];
      end
    end
    return tab;
  endfunction

  function automatic coef_col_t cell_column(gen_tab_t tab, int idx);
    coef_col_t col;
    col = '0;
    for (int n = 0; n < Slots; n++) begin
      if (n > idx) begin
        col[n] = tab[n][n-1-idx];
      end
    end
    return col;
  endfunction

endpackage

[hdl/qrrs_cell.sv]
// One parity cell: a remainder byte with its generator coefficient and a drain byte.
module qrrs_cell import qrrs_pkg::*; #(
  parameter int         INDEX      = 0,
  parameter logic [8:0] FIELD_POLY = 9'h11D,
  parameter coef_col_t  COEF_TAB   = '0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  gf_t        par_next_i,
  input  gf_t        drain_next_i,
  output gf_t        par_o,
  output gf_t        drain_o
);

  localparam len_t          Idx     = len_t'(INDEX);
  localparam logic [LenW:0] IdxP1   = (LenW+1)'(INDEX + 1);
  localparam len_t          RstLen  = len_t'(ResetLen);

  gf_t  par_q, par_d;
  gf_t  drain_q, drain_d;
  gf_t  coef_q;
  logic act_q;
  logic tail_q;
  gf_t  prod;
  gf_t  shifted;

  always_comb begin
    prod    = gf_mul(ctrl_i.fb, coef_q, FIELD_POLY);
    shifted = act_q ? ((tail_q ? gf_t'(0) : par_next_i) ^ prod) : par_q;
    par_d   = par_q;
    if (ctrl_i.clear) begin
      par_d = '0;
    end else if (ctrl_i.step) begin
      par_d = shifted;
    end
    drain_d = drain_q;
    if (ctrl_i.load_drain) begin
      drain_d = ctrl_i.zero_drain ? gf_t'(0) : shifted;
    end else if (ctrl_i.drain_shift) begin
      drain_d = drain_next_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q   <= '0;
      drain_q <= '0;
      coef_q  <= COEF_TAB[RstLen];
      act_q   <= (Idx < RstLen);
      tail_q  <= ({1'b0, RstLen} == IdxP1);
    end else begin
      par_q   <= par_d;
      drain_q <= drain_d;
      if (ctrl_i.cfg_we) begin
        coef_q <= COEF_TAB[ctrl_i.cfg_len];
        act_q  <= ctrl_i.cfg_ok && (Idx < ctrl_i.cfg_len);
        tail_q <= ({1'b0, ctrl_i.cfg_len} == IdxP1);
      end
    end
  end

  assign par_o   = par_q;
  assign drain_o = drain_q;

endmodule

[hdl/qr_reed_solomon_encoder_core.sv]
// Top level of the systematic QR-code Reed-Solomon encoder over GF(256).
// Each data byte is taken, passed through to the output and folded
// into a row of parity cells, one cell per parity byte, each with its own GF multiplier
// by a stored generator coefficient, so data bytes stream at one per cycle unless the
// output stalls. After the byte marked last, the remainder moves into a drain chain in
// the same cells and the parity bytes leave one per cycle unless the output stalls; the
// input holds ready low while parity bytes remain to be sent. Writing ec_length loads
// the new generator coefficients into the cells. An unsupported length raises bad_length
// and yields parity bytes of zero, as many as ec_length limited to MAX_PARITY and
// to 30.
module qr_reed_solomon_encoder_core import qrrs_pkg::*; #(
  parameter int         MAX_PARITY = 30,
  parameter logic [8:0] FIELD_POLY = 9'h11D
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [4:0] ec_length_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       is_parity_o,
  output logic       last_out_o,
  output logic       bad_length_o
);

  localparam gen_tab_t GEN_TAB  = gen_table(FIELD_POLY, MAX_PARITY);
  localparam len_t     CountCap = len_t'((MAX_PARITY < ResultCap) ? MAX_PARITY : ResultCap);
  localparam len_t     RstLen   = len_t'(ResetLen);

  gf_t        par_w   [MAX_PARITY];
  gf_t        drain_w [MAX_PARITY];
  cell_ctrl_t ctrl;

  logic bad_q;
  len_t count_q;
  len_t drain_cnt_q, drain_cnt_d;
  logic cfg_ok;
  len_t count_d;
  logic cfg_we;
  logic free;
  logic draining;
  logic accept;
  logic emit_par;

  logic out_valid_q, out_valid_d;
  gf_t  out_byte_q, out_byte_d;
  logic is_par_q, is_par_d;
  logic last_q, last_d;
  logic bad_out_q, bad_out_d;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_ok      = length_ok(ec_length_i, MAX_PARITY);
  assign count_d     = cfg_ok ? ec_length_i :
                       ((ec_length_i > CountCap) ? CountCap : ec_length_i);

  assign free       = !out_valid_q || out_ready_i;
  assign draining   = (drain_cnt_q != '0);
  assign in_ready_o = free && !draining;
  assign accept     = in_valid_i && in_ready_o;
  assign emit_par   = free && draining;

  always_comb begin
    ctrl.cfg_we      = cfg_we;
    ctrl.cfg_len     = ec_length_i;
    ctrl.cfg_ok      = cfg_ok;
    ctrl.step        = accept && !bad_q;
    ctrl.clear       = accept && last_data_i;
    ctrl.load_drain  = accept && last_data_i;
    ctrl.zero_drain  = bad_q;
    ctrl.drain_shift = emit_par;
    ctrl.fb          = data_byte_i ^ par_w[0];
  end

  for (genvar i = 0; i < MAX_PARITY; i++) begin : g_cell
    localparam coef_col_t CellTab = cell_column(GEN_TAB, i);
    gf_t par_next;
    gf_t drain_next;
    if (i == MAX_PARITY - 1) begin : g_end
      assign par_next   = '0;
      assign drain_next = '0;
    end else begin : g_mid
      assign par_next   = par_w[i+1];
      assign drain_next = drain_w[i+1];
    end
    qrrs_cell #(
      .INDEX      (i),
      .FIELD_POLY (FIELD_POLY),
      .COEF_TAB   (CellTab)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .par_next_i   (par_next),
      .drain_next_i (drain_next),
      .par_o        (par_w[i]),
      .drain_o      (drain_w[i])
    );
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    is_par_d    = is_par_q;
    last_d      = last_q;
    bad_out_d   = bad_out_q;
    drain_cnt_d = drain_cnt_q;
    if (accept) begin
      out_valid_d = 1'b1;
      out_byte_d  = data_byte_i;
      is_par_d    = 1'b0;
      last_d      = last_data_i && (count_q == '0);
      bad_out_d   = bad_q;
      if (last_data_i) begin
        drain_cnt_d = count_q;
      end
    end else if (emit_par) begin
      out_valid_d = 1'b1;
      out_byte_d  = drain_w[0];
      is_par_d    = 1'b1;
      last_d      = (drain_cnt_q == len_t'(1));
      bad_out_d   = bad_q;
      drain_cnt_d = drain_cnt_q - len_t'(1);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bad_q       <= 1'b0;
      count_q     <= RstLen;
      drain_cnt_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we) begin
        bad_q   <= !cfg_ok;
        count_q <= count_d;
      end
      drain_cnt_q <= drain_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    is_par_q   <= is_par_d;
    last_q     <= last_d;
    bad_out_q  <= bad_out_d;
  end

  assign out_valid_o  = out_valid_q;
  assign out_byte_o   = out_byte_q;
  assign is_parity_o  = is_par_q;
  assign last_out_o   = last_q;
  assign bad_length_o = bad_out_q;

endmodule

[hdl/qrrs_checker.sv]
// Port-level checker for the QR Reed-Solomon encoder and its bind to the top level.
module qrrs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       cfg_valid_i,
  input logic       cfg_ready_o,
  input logic [4:0] ec_length_i,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] data_byte_i,
  input logic       last_data_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] out_byte_o,
  input logic       is_parity_o,
  input logic       last_out_o,
  input logic       bad_length_o
);

  // A result that is not taken stays on the output unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o)
      && $stable(is_parity_o) && $stable(last_out_o))
    else $error("output request changed while stalled");

  // An accepted data byte shows up as the next result, unchanged.
  a_pass_through: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o && !is_parity_o
      && (out_byte_o == $past(data_byte_i)))
    else $error("data byte not passed through");

  // No new data request is taken while parity bytes remain to be sent.
  a_no_input_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_parity_o && !last_out_o |-> !in_ready_o)
    else $error("input accepted during parity output");

  // The final parity byte ends the codeword.
  a_drain_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && is_parity_o && last_out_o |=>
      !(out_valid_o && is_parity_o))
    else $error("parity continued after last parity byte");

endmodule

bind qr_reed_solomon_encoder_core qrrs_checker u_qrrs_checker (.*);
